// ===== hw/rtl/bpds_pkg.sv =====
`timescale 1ns / 1ps

package bpds_pkg;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 13;
  localparam int COL_W     = 13;
  localparam int CNT_W     = 7;
  localparam int IMG_W_W   = 13;
  localparam int PAL_W     = 11;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_MODE    = 2'd0,
    CFG_IMAGE_WIDTH   = 2'd1,
    CFG_PALETTE_BYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_LIMIT   = 2'd2
  } kind_t;

  typedef enum logic {
    PHASE_PALETTE = 1'b0,
    PHASE_PIXELS  = 1'b1
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic              first_item;
  } in_item_t;

  typedef struct packed {
    logic               depth_mode;
    logic [IMG_W_W-1:0] image_width;
    logic [PAL_W-1:0]   palette_bytes;
  } cfg_t;

endpackage

// ===== hw/rtl/bpds_if.sv =====
`timescale 1ns / 1ps

interface bpds_in_if;
  import bpds_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_a;
  logic [BYTE_W-1:0] byte_b;
  logic              first_item;

  modport source (output valid, output byte_a, output byte_b, output first_item,
                  input ready);
  modport sink   (input valid, input byte_a, input byte_b, input first_item,
                  output ready);
endinterface

interface bpds_out_if;
  import bpds_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;
  logic [CNT_W-1:0]  diff_count;

  modport source (output valid, output result_kind, output row, output column,
                  output diff_count, input ready);
  modport sink   (input valid, input result_kind, input row, input column,
                  input diff_count, output ready);
endinterface

// ===== hw/rtl/bpds_cfg_regs.sv =====
`timescale 1ns / 1ps

module bpds_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bpds_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bpds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bpds_pkg::cfg_t                     cfg
);
  import bpds_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode    <= 1'b1;
      cfg_r.image_width   <= IMG_W_W'(1);
      cfg_r.palette_bytes <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEPTH_MODE:    cfg_r.depth_mode    <= cfg_wdata[0];
        CFG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_wdata[IMG_W_W-1:0];
        CFG_PALETTE_BYTES: cfg_r.palette_bytes <= cfg_wdata[PAL_W-1:0];
        default: ;  // unused index, write ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/bpds_in_stage.sv =====
`timescale 1ns / 1ps

module bpds_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  bpds_in_if.sink            in_if,
  input  logic               take,
  output logic               item_valid,
  output bpds_pkg::in_item_t item
);
  import bpds_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_if.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.byte_a     <= in_if.byte_a;
      item_r.byte_b     <= in_if.byte_b;
      item_r.first_item <= in_if.first_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/bpds_core.sv =====
`timescale 1ns / 1ps

module bpds_core #(
  parameter int MAX_WIDTH       = 4096,
  parameter int MAX_ROWS        = 4096,
  parameter int MAX_DIFFERENCES = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpds_pkg::cfg_t     cfg,
  input  logic               item_valid,
  input  bpds_pkg::in_item_t item,
  output logic               take,
  bpds_out_if.source         out_if
);
  import bpds_pkg::*;

  // widths derived from the limits
  localparam int CW  = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;
  localparam int SW  = CW + 2;
  localparam int PW  = $clog2(3 * MAX_WIDTH + 4);
  localparam int PW1 = PW + 1;
  localparam int MW  = 2 * PW + 1;
  localparam int RW  = $clog2(MAX_ROWS + 2);
  localparam int DW  = $clog2(MAX_DIFFERENCES + 2);

  localparam logic [CW-1:0]  W_MAX     = CW'(MAX_WIDTH);
  localparam logic [RW-1:0]  ROW_LIMIT = RW'(MAX_ROWS);
  localparam logic [DW-1:0]  TOT_LIMIT = DW'(MAX_DIFFERENCES + 1);
  // reciprocal of three, exact for any PW-bit dividend
  localparam logic [PW:0]    DIV3_M    = PW1'(((64'd1 << PW1) + 64'd2) / 64'd3);

  // run state
  phase_t            phase_r,   phase_nxt;
  logic [PAL_W-1:0]  pal_idx_r, pal_idx_nxt;
  logic [RW-1:0]     row_r,     row_nxt;
  logic [PW-1:0]     pos_r,     pos_nxt;
  logic [1:0]        bip_r,     bip_nxt;
  logic              counted_r, counted_nxt;
  logic [DW-1:0]     total_r,   total_nxt;
  logic              stopped_r, stopped_nxt;

  // state after an optional clear by first_item
  phase_t            phase_e;
  logic [PAL_W-1:0]  pal_idx_e;
  logic [RW-1:0]     row_e;
  logic [PW-1:0]     pos_e;
  logic [1:0]        bip_e;
  logic              counted_e;
  logic [DW-1:0]     total_e;
  logic              stopped_e;

  logic [CW-1:0]     w_c;
  logic [SW-1:0]     sig, sig_p3, rowlen, pos_x, pos_p1;
  logic [MW-1:0]     prod;
  logic [PW-1:0]     q3;
  logic              differ, pix_go, hit, counted_t;
  logic [DW-1:0]     tot_inc;

  logic              produce;
  kind_t             kind;
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_col;
  logic [CNT_W-1:0]  res_cnt;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [CNT_W-1:0]  out_cnt_r;

  assign take = item_valid && (!out_valid_r || out_if.ready);

  // row geometry
  always_comb begin
    w_c = CW'(cfg.image_width);
    if (w_c == '0) begin
      w_c = CW'(1);
    end else if (w_c > W_MAX) begin
      w_c = W_MAX;
    end
    sig    = cfg.depth_mode ? (SW'(w_c) + (SW'(w_c) << 1)) : SW'(w_c);
    sig_p3 = sig + SW'(3);
    rowlen = {sig_p3[SW-1:2], 2'b00};
  end

  always_comb begin
    if (item.first_item) begin
      phase_e   = PHASE_PALETTE;
      pal_idx_e = '0;
      row_e     = RW'(1);
      pos_e     = '0;
      bip_e     = '0;
      counted_e = 1'b0;
      total_e   = '0;
      stopped_e = 1'b0;
    end else begin
      phase_e   = phase_r;
      pal_idx_e = pal_idx_r;
      row_e     = row_r;
      pos_e     = pos_r;
      bip_e     = bip_r;
      counted_e = counted_r;
      total_e   = total_r;
      stopped_e = stopped_r;
    end
  end

  // pixel column in 24-bit mode: byte position divided by three
  assign prod   = MW'(pos_e) * MW'(DIV3_M);
  assign q3     = prod[MW-1:PW1];
  assign pos_x  = SW'(pos_e);
  assign pos_p1 = pos_x + SW'(1);
  assign differ = (item.byte_a != item.byte_b);
  assign tot_inc = total_e + DW'(1);

  always_comb begin
    phase_nxt   = phase_e;
    pal_idx_nxt = pal_idx_e;
    row_nxt     = row_e;
    pos_nxt     = pos_e;
    bip_nxt     = bip_e;
    counted_nxt = counted_e;
    total_nxt   = total_e;
    stopped_nxt = stopped_e;
    produce     = 1'b0;
    kind        = KIND_PIXEL;
    res_row     = '0;
    res_col     = '0;
    res_cnt     = '0;
    pix_go      = 1'b0;
    hit         = 1'b0;
    counted_t   = counted_e;

    if (!stopped_e) begin
      if (phase_e == PHASE_PALETTE) begin
        if (!cfg.depth_mode && (pal_idx_e < cfg.palette_bytes)) begin
          pal_idx_nxt = pal_idx_e + PAL_W'(1);
          // every fourth palette byte is reserved and not compared
          if ((pal_idx_e[1:0] != 2'b11) && differ) begin
            stopped_nxt = 1'b1;
            produce     = 1'b1;
            kind        = KIND_PALETTE;
          end
        end else begin
          phase_nxt = PHASE_PIXELS;
          pix_go    = 1'b1;
        end
      end else begin
        pix_go = 1'b1;
      end

      if (pix_go && (row_e <= ROW_LIMIT)) begin
        if (pos_x < sig) begin
          if (cfg.depth_mode) begin
            counted_t   = (bip_e == 2'd0) ? 1'b0 : counted_e;
            hit         = differ && !counted_t;
            counted_nxt = counted_t || hit;
            bip_nxt     = (bip_e >= 2'd2) ? 2'd0 : bip_e + 2'd1;
            res_col     = COL_W'(q3 + PW'(1));
          end else begin
            hit     = differ;
            res_col = COL_W'(pos_p1);
          end
          if (hit) begin
            total_nxt = tot_inc;
            produce   = 1'b1;
            res_row   = ROW_W'(row_e);
            res_cnt   = CNT_W'(tot_inc);
            if (tot_inc == TOT_LIMIT) begin
              stopped_nxt = 1'b1;
              kind        = KIND_LIMIT;
            end
          end
        end
        // row end, padding included
        if (pos_p1 >= rowlen) begin
          pos_nxt     = '0;
          bip_nxt     = '0;
          counted_nxt = 1'b0;
          row_nxt     = row_e + RW'(1);
        end else begin
          pos_nxt = PW'(pos_p1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_PALETTE;
      pal_idx_r   <= '0;
      row_r       <= RW'(1);
      pos_r       <= '0;
      bip_r       <= '0;
      counted_r   <= 1'b0;
      total_r     <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        pal_idx_r   <= pal_idx_nxt;
        row_r       <= row_nxt;
        pos_r       <= pos_nxt;
        bip_r       <= bip_nxt;
        counted_r   <= counted_nxt;
        total_r     <= total_nxt;
        stopped_r   <= stopped_nxt;
        out_valid_r <= produce;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      out_kind_r <= kind;
      out_row_r  <= res_row;
      out_col_r  <= res_col;
      out_cnt_r  <= res_cnt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.result_kind = out_kind_r;
  assign out_if.row         = out_row_r;
  assign out_if.column      = out_col_r;
  assign out_if.diff_count  = out_cnt_r;

endmodule

// ===== hw/rtl/bitmap_pixel_difference_scanner_top.sv =====
`timescale 1ns / 1ps

// channel   direction  payload                                  handshake
// in_if     sink       byte_a, byte_b, first_item               valid / ready
// out_if    source     result_kind, row, column, diff_count     valid / ready
// cfg_*     write      cfg_idx, cfg_wdata                       cfg_we, no wait
//
// one byte pair per cycle unless the output stalls; a pair passes the input
// register and then the result register around the compare logic
// pairs that cause no result are absorbed without an output transfer
// synchronous active-low reset clears the run state to the start of a comparison
// a stalled output holds its result while one more input transfer is buffered

module bitmap_pixel_difference_scanner_top #(
  parameter int MAX_WIDTH       = 4096,
  parameter int MAX_ROWS        = 4096,
  parameter int MAX_DIFFERENCES = 100
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bpds_in_if.sink                         in_if,
  bpds_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [bpds_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bpds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpds_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid;
  logic     take;

  // configuration registers, taken straight by the compare logic
  bpds_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register; refills in the same cycle the core takes its item
  bpds_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // position counters, comparison, difference count and result register
  bpds_core #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_ROWS        (MAX_ROWS),
    .MAX_DIFFERENCES (MAX_DIFFERENCES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_if     (out_if)
  );

endmodule
